FILE: src/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg: shared definitions for the keyed LRU cache
// Field widths and positions on the stream ports, operation codes, controller
// states, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lkc_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    localparam int KEY_W    = 64;
    localparam int PAY_IN_W = 32;
    localparam int OCC_W    = 5;
    localparam int OP_W     = 2;

    // input stream: tdata = {payload, key}, tuser = operation
    localparam int KEY_LSB   = 0;
    localparam int PAY_LSB   = KEY_LSB + KEY_W;
    localparam int S_TDATA_W = PAY_LSB + PAY_IN_W;
    localparam int S_TUSER_W = OP_W;

    // output stream: tdata = {pad, occupancy, evicted_key, data_out},
    // tuser = {evicted, hit}
    localparam int DATA_LSB  = 0;
    localparam int EVK_LSB   = DATA_LSB + PAY_IN_W;
    localparam int OCC_LSB   = EVK_LSB + KEY_W;
    localparam int M_TDATA_W = ((OCC_LSB + OCC_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - OCC_LSB - OCC_W;
    localparam int M_TUSER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_HAS   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_LOOKUP = 2'd1,
        ST_EXEC   = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic exec;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: src/lkc_ctrl.sv
// ----------------------------------------------------------------------------
// lkc_ctrl: operation sequencer
// Steps each accepted transaction through lookup, table update and result
// load, and issues the matching commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lkc_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire lkc_pkg::status_t status,
    output lkc_pkg::cmd_t         cmd
);

    lkc_pkg::state_t state_reg;
    lkc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            lkc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = lkc_pkg::ST_LOOKUP;
                end
            end
            lkc_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = lkc_pkg::ST_EXEC;
            end
            lkc_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = lkc_pkg::ST_FINISH;
            end
            lkc_pkg::ST_FINISH:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    s_tready     = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = lkc_pkg::ST_LOOKUP;
                    end
                    else
                    begin
                        state_next = lkc_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lkc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/lkc_datapath.sv
// ----------------------------------------------------------------------------
// lkc_datapath: key table, recency ranks and result register
// Parallel key match, slot selection, rank update, payload store and the
// output register of the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lkc_datapath
#(
    parameter int CAPACITY      = lkc_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_WIDTH = lkc_pkg::PAYLOAD_WIDTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lkc_pkg::cmd_t                   cmd,
    output lkc_pkg::status_t                     status,
    input  wire logic [lkc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [lkc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [lkc_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [lkc_pkg::M_TUSER_W-1:0]        m_tuser
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = (PAYLOAD_WIDTH < lkc_pkg::PAY_IN_W) ? PAYLOAD_WIDTH
                                                            : lkc_pkg::PAY_IN_W;
    localparam logic [IW-1:0] RANK_LAST = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(CAPACITY);

    // captured operation
    lkc_pkg::op_t               op_reg;
    logic [lkc_pkg::KEY_W-1:0]  op_key_reg;
    logic [SW-1:0]              op_pay_reg;

    // table
    logic [lkc_pkg::KEY_W-1:0]  entry_key_reg [CAPACITY];
    logic [SW-1:0]              pay_mem [CAPACITY];
    logic [CAPACITY-1:0]        valid_reg;
    logic [IW-1:0]              rank_reg [CAPACITY];
    logic [IW-1:0]              rank_next [CAPACITY];
    logic [CW-1:0]              count_reg;

    // lookup results
    logic                       hit_reg;
    logic                       full_reg;
    logic [IW-1:0]              slot_reg;
    logic [IW-1:0]              hit_rank_reg;

    // update results
    logic                       ev_reg;
    logic [lkc_pkg::KEY_W-1:0]  evk_reg;
    logic [SW-1:0]              rd_reg;

    // output register
    logic                          m_tvalid_reg;
    logic [lkc_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [lkc_pkg::M_TUSER_W-1:0] m_tuser_reg;

    // lookup logic
    logic [CAPACITY-1:0]        hit_vec;
    logic                       hit_any;
    logic [IW-1:0]              hit_idx;
    logic [IW-1:0]              hit_rank;
    logic [IW-1:0]              free_idx;
    logic [IW-1:0]              victim_idx;
    logic                       full_now;

    // update control
    logic                       is_insert;
    logic                       do_rank;
    logic                       out_hit;
    logic [lkc_pkg::PAY_IN_W-1:0] out_data;

    always_comb
    begin
        hit_idx    = '0;
        hit_rank   = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_vec[i] = valid_reg[i] && (entry_key_reg[i] == op_key_reg);
            if (hit_vec[i])
            begin
                hit_idx = IW'(i);
            end
            hit_rank = hit_rank | (rank_reg[i] & {IW{hit_vec[i]}});
            // the oldest entry, used only when the table is full
            if (valid_reg[i] && (rank_reg[i] == RANK_LAST))
            begin
                victim_idx = IW'(i);
            end
        end
        // lowest-numbered free slot
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
        hit_any  = |hit_vec;
        full_now = (count_reg == COUNT_FULL);
    end

    assign is_insert = (op_reg == lkc_pkg::OP_PUT) && !hit_reg;
    assign do_rank   = is_insert
                    || (hit_reg && ((op_reg == lkc_pkg::OP_PUT) || (op_reg == lkc_pkg::OP_GET)));

    // age the entries ahead of the touched slot, put the touched slot at rank zero
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (IW'(i) == slot_reg)
            begin
                rank_next[i] = '0;
            end
            else if (valid_reg[i] && (is_insert || (rank_reg[i] < hit_rank_reg)))
            begin
                rank_next[i] = rank_reg[i] + IW'(1);
            end
            else
            begin
                rank_next[i] = rank_reg[i];
            end
        end
    end

    // operation capture, lookup results, update results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= lkc_pkg::op_t'(s_tuser);
            op_key_reg <= s_tdata[lkc_pkg::KEY_LSB +: lkc_pkg::KEY_W];
            op_pay_reg <= SW'(s_tdata[lkc_pkg::PAY_LSB +: lkc_pkg::PAY_IN_W]);
        end
        if (cmd.lookup)
        begin
            hit_reg      <= hit_any;
            full_reg     <= full_now;
            hit_rank_reg <= hit_rank;
            if (hit_any)
            begin
                slot_reg <= hit_idx;
            end
            else if (full_now)
            begin
                slot_reg <= victim_idx;
            end
            else
            begin
                slot_reg <= free_idx;
            end
        end
        if (cmd.exec)
        begin
            rd_reg <= pay_mem[slot_reg];
            if (is_insert && full_reg)
            begin
                ev_reg  <= 1'b1;
                evk_reg <= entry_key_reg[slot_reg];
            end
            else
            begin
                ev_reg  <= 1'b0;
                evk_reg <= '0;
            end
            if (is_insert)
            begin
                entry_key_reg[slot_reg] <= op_key_reg;
                pay_mem[slot_reg]       <= op_pay_reg;
            end
        end
    end

    // valid bits, ranks and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (op_reg == lkc_pkg::OP_CLEAR)
            begin
                valid_reg <= '0;
                count_reg <= '0;
                for (int i = 0; i < CAPACITY; i++)
                begin
                    rank_reg[i] <= '0;
                end
            end
            else
            begin
                if (do_rank)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        rank_reg[i] <= rank_next[i];
                    end
                end
                if (is_insert)
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    if (!full_reg)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
            end
        end
    end

    assign out_hit  = hit_reg && (op_reg != lkc_pkg::OP_CLEAR);
    assign out_data = (out_hit && (op_reg == lkc_pkg::OP_GET))
                    ? lkc_pkg::PAY_IN_W'(rd_reg) : '0;

    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tdata_reg <= {{lkc_pkg::M_PAD_W{1'b0}},
                            lkc_pkg::OCC_W'(count_reg),
                            evk_reg,
                            out_data};
            m_tuser_reg <= {ev_reg, out_hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: src/lru_keyed_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_keyed_cache_unit: fully associative cache with least-recently-used order
// Top level: sequencer plus key table datapath on a pair of streams.
// ----------------------------------------------------------------------------
// The unit holds up to CAPACITY entries, each a 64-bit key with a payload of
// PAYLOAD_WIDTH bits (at most 32 are kept), and keeps a strict recency order
// among them. Every input transaction carries one operation and yields exactly
// one result transaction. Put on a miss stores the entry in the lowest free
// slot or, when the table is full, in place of the least recent entry, whose
// key is reported; put on a hit only makes the entry most recent and keeps the
// stored payload. Get on a hit returns the payload and makes the entry most
// recent; on a miss it reports hit=0 and changes nothing. Has tests for the
// key and leaves the order alone. Clear empties the table. Each result carries
// the occupancy after the operation. After acceptance an operation passes
// through lookup, table update and result load into the output register,
// and a new transaction is taken in the same cycle the previous result is
// loaded, so the unit takes a new operation only as the previous one loads
// its result, while the output side keeps up. The three sequencer steps that
// follow acceptance are one registered stage each. A stalled output holds the
// finished result and the next transaction waits at the input.
`default_nettype none

module lru_keyed_cache_unit
#(
    parameter int CAPACITY      = lkc_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_WIDTH = lkc_pkg::PAYLOAD_WIDTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata, from bit 0 up: key (64), payload (32)
    input  wire logic [lkc_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser, from bit 0 up: operation (2)
    input  wire logic [lkc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata, from bit 0 up: data_out (32), evicted_key (64), occupancy (5),
    // zero pad (3)
    output logic [lkc_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser, from bit 0 up: hit (1), evicted (1)
    output logic [lkc_pkg::M_TUSER_W-1:0]        m_tuser
);

    lkc_pkg::cmd_t    cmd;
    lkc_pkg::status_t status;

    // sequence each transaction: capture, lookup, update, load result
    lkc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // key table, recency ranks, payload store and output register
    lkc_datapath
    #(
        .CAPACITY      (CAPACITY),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: src/lkc_checker.sv
// ----------------------------------------------------------------------------
// lkc_checker: port-level checks for the keyed LRU cache
// Watches the result stream for consistency between flags and fields.
// ----------------------------------------------------------------------------
`default_nettype none

module lkc_checker
#(
    parameter int CAPACITY = lkc_pkg::CAPACITY_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [lkc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic [lkc_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam logic [lkc_pkg::OCC_W-1:0] OCC_FULL = lkc_pkg::OCC_W'(CAPACITY);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // eviction only on a miss
    a_ev_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("eviction reported on a hit");

    // eviction only from a full table, which stays full
    a_ev_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[lkc_pkg::OCC_LSB +: lkc_pkg::OCC_W] == OCC_FULL)
        else $error("eviction with table not full");

    // no evicted key without eviction
    a_evk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[lkc_pkg::EVK_LSB +: lkc_pkg::KEY_W] == '0)
        else $error("evicted key without eviction");

    // occupancy never exceeds the table size (checked only when CAPACITY is at most 31)
    a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (CAPACITY > 31)
                  || (m_tdata[lkc_pkg::OCC_LSB +: lkc_pkg::OCC_W] <= OCC_FULL))
        else $error("occupancy above capacity");

endmodule

bind lru_keyed_cache_unit lkc_checker
#(
    .CAPACITY (CAPACITY)
)
u_lkc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
